// File: sv/kpu_pkg.sv
`default_nettype none

package kpu_pkg;

    localparam int unsigned LenW  = 5;
    localparam int unsigned RankW = 62;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_LOAD,
        ST_DIV,
        ST_EMIT
    } t_state;

    // m! for m = 0..20; zero for codes that have no entry
    function automatic logic [RankW-1:0] fact(input logic [LenW-1:0] m);
        logic [RankW-1:0] f;
        case (m)
            5'd0:    f = 62'd1;
            5'd1:    f = 62'd1;
            5'd2:    f = 62'd2;
            5'd3:    f = 62'd6;
            5'd4:    f = 62'd24;
            5'd5:    f = 62'd120;
            5'd6:    f = 62'd720;
            5'd7:    f = 62'd5040;
            5'd8:    f = 62'd40320;
            5'd9:    f = 62'd362880;
            5'd10:   f = 62'd3628800;
            5'd11:   f = 62'd39916800;
            5'd12:   f = 62'd479001600;
            5'd13:   f = 62'd6227020800;
            5'd14:   f = 62'd87178291200;
            5'd15:   f = 62'd1307674368000;
            5'd16:   f = 62'd20922789888000;
            5'd17:   f = 62'd355687428096000;
            5'd18:   f = 62'd6402373705728000;
            5'd19:   f = 62'd121645100408832000;
            5'd20:   f = 62'd2432902008176640000;
            default: f = '0;
        endcase
        return f;
    endfunction

endpackage

`default_nettype wire

// File: sv/kpu_if.sv
`default_nettype none

interface kpu_in_if;
    logic        valid;
    logic        ready;
    logic [4:0]  length;
    logic [61:0] rank;

    modport source (output valid, output length, output rank, input ready);
    modport sink   (input valid, input length, input rank, output ready);
endinterface

interface kpu_out_if;
    logic       valid;
    logic       ready;
    logic [4:0] element;
    logic [4:0] position;
    logic       last;
    logic       error;

    modport source (output valid, output element, output position, output last,
                    output error, input ready);
    modport sink   (input valid, input element, input position, input last,
                    input error, output ready);
endinterface

`default_nettype wire

// File: sv/kth_permutation_unrank.sv
// Lexicographic permutation unranking.
// Input channel i_in carries a length n and a one-based rank k; output
// channel o_out returns the k-th permutation of 1..n, one transaction per
// position, with last set on the final one. A rank of zero or above n!, or a
// length of zero or above MAX_LEN, gives one transaction with element 0,
// position 0, last 1 and error 1.
// One item is worked on at a time; i_in.ready is high only while idle.
// For each position, with m numbers still unused, the sequencer loads (m-1)!,
// then runs compare-subtract steps on the remaining rank, each of which moves
// the pick to the next unused number, until the remainder falls below
// (m-1)!; it then picks that number and places it in the output register.
// A single 62-bit compare-subtract unit does this division by repeated
// subtraction. A stalled result holds in the output register and the
// sequencer waits.
// Reset (synchronous, active low) returns the block to idle with no result
// pending.
`default_nettype none

module kth_permutation_unrank
    import kpu_pkg::*;
#(
    parameter int unsigned MAX_LEN = 20
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    kpu_in_if.sink       i_in,
    kpu_out_if.source    o_out
);

    localparam int unsigned PtrW = $clog2(MAX_LEN);
    localparam logic [LenW-1:0] MaxLenL = LenW'(MAX_LEN);

    function automatic logic [PtrW-1:0] lowest_set(input logic [MAX_LEN-1:0] v);
        logic [PtrW-1:0] idx;
        idx = '0;
        for (int i = MAX_LEN - 1; i >= 0; i--) begin
            if (v[i]) begin
                idx = PtrW'(i);
            end
        end
        return idx;
    endfunction

    t_state               r_state, n_state;
    logic [LenW-1:0]      r_len, n_len;
    logic [RankW-1:0]     r_rank, n_rank;
    logic [RankW-1:0]     r_rem, n_rem;
    logic [RankW-1:0]     r_fact, n_fact;
    logic [MAX_LEN-1:0]   r_mask, n_mask;
    logic [PtrW-1:0]      r_ptr, n_ptr;
    logic [LenW-1:0]      r_pos, n_pos;
    logic [LenW-1:0]      r_element, n_element;
    logic [LenW-1:0]      r_position, n_position;
    logic                 r_last, n_last;
    logic                 r_error, n_error;

    logic                 bad_item;
    logic [MAX_LEN-1:0]   init_mask;
    logic [MAX_LEN-1:0]   above_ptr;
    logic [MAX_LEN-1:0]   ptr_bit;

    always_comb begin
        for (int i = 0; i < MAX_LEN; i++) begin
            init_mask[i] = (LenW'(i) < r_len);
            above_ptr[i] = (PtrW'(i) > r_ptr);
            ptr_bit[i]   = (PtrW'(i) == r_ptr);
        end
    end

    assign bad_item = (r_len == '0) || (r_len > MaxLenL) || (r_rank == '0) ||
                      (r_rank > fact(r_len));

    always_comb begin
        n_state    = r_state;
        n_len      = r_len;
        n_rank     = r_rank;
        n_rem      = r_rem;
        n_fact     = r_fact;
        n_mask     = r_mask;
        n_ptr      = r_ptr;
        n_pos      = r_pos;
        n_element  = r_element;
        n_position = r_position;
        n_last     = r_last;
        n_error    = r_error;

        case (r_state)
            ST_IDLE: begin
                if (i_in.valid) begin
                    n_len   = i_in.length;
                    n_rank  = i_in.rank;
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (bad_item) begin
                    n_element  = '0;
                    n_position = '0;
                    n_last     = 1'b1;
                    n_error    = 1'b1;
                    n_state    = ST_EMIT;
                end else begin
                    n_rem   = r_rank - RankW'(1);
                    n_mask  = init_mask;
                    n_pos   = '0;
                    n_error = 1'b0;
                    n_state = ST_LOAD;
                end
            end
            ST_LOAD: begin
                n_fact  = fact(r_len - r_pos - LenW'(1));
                n_ptr   = lowest_set(r_mask);
                n_state = ST_DIV;
            end
            ST_DIV: begin
                // each subtraction steps the pick to the next unused number
                if (r_rem >= r_fact) begin
                    n_rem = r_rem - r_fact;
                    n_ptr = lowest_set(r_mask & above_ptr);
                end else begin
                    n_mask     = r_mask & ~ptr_bit;
                    n_element  = LenW'(r_ptr) + LenW'(1);
                    n_position = r_pos;
                    n_last     = (r_pos == r_len - LenW'(1));
                    n_state    = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (o_out.ready) begin
                    if (r_last) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_pos   = r_pos + LenW'(1);
                        n_state = ST_LOAD;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_len      <= n_len;
        r_rank     <= n_rank;
        r_rem      <= n_rem;
        r_fact     <= n_fact;
        r_mask     <= n_mask;
        r_ptr      <= n_ptr;
        r_pos      <= n_pos;
        r_element  <= n_element;
        r_position <= n_position;
        r_last     <= n_last;
        r_error    <= n_error;
    end

    assign i_in.ready     = (r_state == ST_IDLE);
    assign o_out.valid    = (r_state == ST_EMIT);
    assign o_out.element  = r_element;
    assign o_out.position = r_position;
    assign o_out.last     = r_last;
    assign o_out.error    = r_error;

endmodule

`default_nettype wire
